// ===== hdl/fsig_pkg.sv =====
// ----------------------------------------------------------------------------
// fsig_pkg
// Shared types and constants for the file name signature core.
// ----------------------------------------------------------------------------
package fsig_pkg;

  localparam int unsigned CH_W       = 16;
  localparam int unsigned SIG_W      = 64;
  localparam int unsigned NUM_LETTERS = 26;
  localparam int unsigned NUM_PAIRS  = 20;
  localparam int unsigned FEAT_W     = 39;
  localparam int unsigned LEN_W      = 3;
  localparam int unsigned CNT_W      = 2;

  localparam logic [5:0] BIT_DIGIT0 = 6'd26;
  localparam logic [5:0] BIT_DOT    = 6'd36;
  localparam logic [5:0] BIT_SPACE  = 6'd37;
  localparam logic [5:0] BIT_PUNCT  = 6'd38;

  localparam logic [LEN_W-1:0] LEN_MAX = 3'd7;
  localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;
  localparam logic [CNT_W-1:0] CNT_TWO = 2'd2;

  localparam logic [CH_W-1:0] CH_LOWER_A = 16'h0061;
  localparam logic [CH_W-1:0] CH_LOWER_Z = 16'h007a;
  localparam logic [CH_W-1:0] CH_ZERO    = 16'h0030;
  localparam logic [CH_W-1:0] CH_NINE    = 16'h0039;
  localparam logic [CH_W-1:0] CH_DOT     = 16'h002e;
  localparam logic [CH_W-1:0] CH_SPACE   = 16'h0020;

  typedef logic [4:0] letter_idx_t;

  // th he an re er in on at nd st es en of te ed or ti hi as to
  localparam letter_idx_t PAIR_FIRST [NUM_PAIRS] = '{
    5'd19, 5'd7,  5'd0,  5'd17, 5'd4,  5'd8,  5'd14, 5'd0,  5'd13, 5'd18,
    5'd4,  5'd4,  5'd14, 5'd19, 5'd4,  5'd14, 5'd19, 5'd7,  5'd0,  5'd19
  };
  localparam letter_idx_t PAIR_SECOND [NUM_PAIRS] = '{
    5'd7,  5'd4,  5'd13, 5'd4,  5'd17, 5'd13, 5'd13, 5'd19, 5'd3,  5'd19,
    5'd18, 5'd13, 5'd5,  5'd4,  5'd3,  5'd17, 5'd8,  5'd8,  5'd18, 5'd14
  };

  typedef struct packed {
    logic                  letter;
    letter_idx_t           idx;
    logic [FEAT_W-1:0]     feat;
    logic [NUM_PAIRS-1:0]  pair;
  } fsig_class_t;

endpackage

// ===== hdl/filename_signature_core.sv =====
// ----------------------------------------------------------------------------
// filename_signature_core
// Builds a 64-bit signature of a file name from a stream of characters.
// ----------------------------------------------------------------------------
// channel | dir | tdata               | tlast
// in_     | in  | [15:0] ch           | last character of the name
// out_    | out | [63:0] signature    | -
//
// One character is taken per cycle unless stalled; the signature is registered
// from the transaction that carries tlast. The output register decouples the
// sides: input is stalled only while a signature waits and out_tready is low.
// Reset (rst_n low, synchronous) clears the name state and the output valid.
// ----------------------------------------------------------------------------
module filename_signature_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [fsig_pkg::CH_W-1:0]  in_tdata,   // [15:0] ch
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [fsig_pkg::SIG_W-1:0] out_tdata   // [63:0] signature
);

  fsig_pkg::fsig_class_t cls;
  logic in_acc;

  logic                                 prev_is_letter_r;
  fsig_pkg::letter_idx_t                prev_letter_r;
  logic [fsig_pkg::CNT_W-1:0]           cnt_r   [fsig_pkg::NUM_LETTERS];
  logic [fsig_pkg::CNT_W-1:0]           cnt_nxt [fsig_pkg::NUM_LETTERS];
  logic [fsig_pkg::FEAT_W-1:0]          feat_r, feat_nxt;
  logic [fsig_pkg::NUM_PAIRS-1:0]       pair_r, pair_nxt;
  logic [fsig_pkg::LEN_W-1:0]           len_r, len_nxt;
  logic                                 dup2, dup3;
  logic [fsig_pkg::SIG_W-1:0]           sig;
  logic                                 out_valid_r;
  logic [fsig_pkg::SIG_W-1:0]           out_data_r;

  fsig_class u_class (
    .ch             (in_tdata),
    .prev_is_letter (prev_is_letter_r),
    .prev_letter    (prev_letter_r),
    .cls            (cls)
  );

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    dup2 = 1'b0;
    dup3 = 1'b0;
    for (int i = 0; i < fsig_pkg::NUM_LETTERS; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (cls.letter && (cls.idx == 5'(i)) && (cnt_r[i] != fsig_pkg::CNT_MAX)) begin
        cnt_nxt[i] = cnt_r[i] + 2'd1;
      end
      dup2 = dup2 | (cnt_nxt[i] == fsig_pkg::CNT_TWO);
      dup3 = dup3 | (cnt_nxt[i] == fsig_pkg::CNT_MAX);
    end
    feat_nxt = feat_r | cls.feat;
    pair_nxt = pair_r | cls.pair;
    len_nxt  = (len_r == fsig_pkg::LEN_MAX) ? len_r : len_r + 3'd1;
    sig      = {len_nxt, pair_nxt, dup3, dup2, feat_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_is_letter_r <= 1'b0;
      prev_letter_r    <= '0;
      feat_r           <= '0;
      pair_r           <= '0;
      len_r            <= '0;
      for (int i = 0; i < fsig_pkg::NUM_LETTERS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (in_acc) begin
      if (in_tlast) begin
        prev_is_letter_r <= 1'b0;
        prev_letter_r    <= '0;
        feat_r           <= '0;
        pair_r           <= '0;
        len_r            <= '0;
        for (int i = 0; i < fsig_pkg::NUM_LETTERS; i++) begin
          cnt_r[i] <= '0;
        end
      end else begin
        prev_is_letter_r <= cls.letter;
        prev_letter_r    <= cls.idx;
        feat_r           <= feat_nxt;
        pair_r           <= pair_nxt;
        len_r            <= len_nxt;
        for (int i = 0; i < fsig_pkg::NUM_LETTERS; i++) begin
          cnt_r[i] <= cnt_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      out_data_r <= sig;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> len_r == '0 && !prev_is_letter_r)
    else $error("name state not cleared after last character");

  a_len_counts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_tlast |=> len_r != '0)
    else $error("length not advanced");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while signature blocked");

  a_sig_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r[63:61] != 3'd0)
    else $error("signature carries zero length");

endmodule

// ===== hdl/fsig_class.sv =====
// ----------------------------------------------------------------------------
// fsig_class
// Classifies one character and matches the letter pair it closes.
// ----------------------------------------------------------------------------
module fsig_class (
  input  logic [fsig_pkg::CH_W-1:0] ch,
  input  logic                      prev_is_letter,
  input  fsig_pkg::letter_idx_t     prev_letter,
  output fsig_pkg::fsig_class_t     cls
);

  logic punct;
  logic [fsig_pkg::CH_W-1:0] ofs;

  always_comb begin
    punct = ((ch >= 16'h0021) && (ch <= 16'h002f)) ||
            ((ch >= 16'h003a) && (ch <= 16'h0040)) ||
            ((ch >= 16'h005b) && (ch <= 16'h0060)) ||
            ((ch >= 16'h007b) && (ch <= 16'h007e));
    ofs        = ch - fsig_pkg::CH_LOWER_A;
    cls        = '0;
    cls.letter = (ch >= fsig_pkg::CH_LOWER_A) && (ch <= fsig_pkg::CH_LOWER_Z);
    if (cls.letter) begin
      cls.idx           = ofs[4:0];
      cls.feat[ofs[5:0]] = 1'b1;
      if (prev_is_letter) begin
        for (int k = 0; k < fsig_pkg::NUM_PAIRS; k++) begin
          cls.pair[k] = (fsig_pkg::PAIR_FIRST[k] == prev_letter) &&
                        (fsig_pkg::PAIR_SECOND[k] == ofs[4:0]);
        end
      end
    end else if ((ch >= fsig_pkg::CH_ZERO) && (ch <= fsig_pkg::CH_NINE)) begin
      cls.feat[fsig_pkg::BIT_DIGIT0 + {2'b00, ch[3:0]}] = 1'b1;
    end else if (ch == fsig_pkg::CH_DOT) begin
      cls.feat[fsig_pkg::BIT_DOT] = 1'b1;
    end else if (ch == fsig_pkg::CH_SPACE) begin
      cls.feat[fsig_pkg::BIT_SPACE] = 1'b1;
    end else if (punct) begin
      cls.feat[fsig_pkg::BIT_PUNCT] = 1'b1;
    end
  end

endmodule
